[src/pbe_pkg.sv]
// Shared types and constants for the pairwise binding energy block.
// Used by every src module but pbe_ram, and by the testbench; depends on nothing.
package pbe_pkg;

    // Reference store size and the index/count widths that follow from it
    localparam int REF_ATOMS = 256;
    localparam int REF_AW    = (REF_ATOMS > 1) ? $clog2(REF_ATOMS) : 1;
    localparam int REF_CW    = $clog2(REF_ATOMS + 1);

    // Configuration register indexes and reset values
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 24;
    localparam logic [CFG_IW-1:0] CFG_EPS    = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_CUTOFF = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_HBOND  = 2'd2;

    localparam logic [15:0]        EPS_RESET    = 16'd6554;
    localparam logic [23:0]        CUTOFF_RESET = 24'd589824;
    localparam logic signed [23:0] HBOND_RESET  = -24'sd196608;

    // Element codes
    localparam logic [6:0] EL_H = 7'd1;
    localparam logic [6:0] EL_N = 7'd7;
    localparam logic [6:0] EL_O = 7'd8;

    // Arithmetic constants
    localparam logic [24:0]        COULOMB_K  = 25'd21762120;   // 332.0636 in Q.16
    localparam logic [49:0]        HB_LO_R2   = 50'd37748736;   // 2.25 in Q.24
    localparam logic [49:0]        HB_HI_R2   = 50'd104857600;  // 6.25 in Q.24
    localparam logic [47:0]        POW_CAP    = 48'h8000_0000_0000;
    localparam logic signed [49:0] D_CAP      = 50'sd140737488355328;
    localparam logic signed [49:0] D_NCAP     = -50'sd140737488355328;
    localparam logic signed [50:0] ACC_MAX    = 51'sd140737488355327;
    localparam logic signed [50:0] ACC_MIN    = -51'sd140737488355328;
    localparam int                 SQRT_STEPS = 18;
    localparam int                 PE_W       = 50;

    // Shared iterative divider
    localparam int DIV_NW = 43;
    localparam int DIV_DW = 18;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    typedef struct packed {
        logic              kind;
        logic [6:0]        element;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [15:0] partial_charge;
        logic [15:0]       vdw_radius;
        logic              last;
    } t_in_item;

    typedef struct packed {
        logic signed [47:0] total_energy;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic [6:0]         element;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [15:0] charge;
        logic [15:0]        radius;
    } t_ref_entry;

    localparam int REF_W = $bits(t_ref_entry);

    typedef struct packed {
        logic [15:0]        eps;
        logic [23:0]        cutoff;
        logic signed [23:0] hbond;
    } t_cfg;

    typedef struct packed {
        logic                   done;
        logic                   sat;
        logic signed [PE_W-1:0] energy;
    } t_pair_res;

endpackage

[src/pbe_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module pbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/pbe_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on pbe_pkg for its widths.
module pbe_div import pbe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_NW-1:0] r_num;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;

    logic [DIV_DW:0]   w_sh;
    logic              w_qbit;
    logic [DIV_DW-1:0] n_rem;

    assign w_sh   = {r_rem, r_num[DIV_NW-1]};
    assign w_qbit = (w_sh >= {1'b0, r_den});
    assign n_rem  = w_qbit ? DIV_DW'(w_sh - {1'b0, r_den}) : w_sh[DIV_DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift into the numerator register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NW-2:0], w_qbit};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

[src/pbe_pair.sv]
// Pair energy sequencer: distance, cutoff, sqrt, Lennard-Jones, Coulomb and hydrogen-bond terms.
// Depends on pbe_pkg and the shared divider pbe_div.
module pbe_pair import pbe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_in_item   i_probe,
    input  t_ref_entry i_ref,
    input  t_cfg       i_cfg,
    output t_pair_res  o_res
);

    typedef enum logic [12:0] {
        P_IDLE = 13'h0001,
        P_SQ   = 13'h0002,
        P_CHK  = 13'h0004,
        P_SQRT = 13'h0008,
        P_TGO  = 13'h0010,
        P_DIVT = 13'h0020,
        P_KMUL = 13'h0040,
        P_CGO  = 13'h0080,
        P_DIVC = 13'h0100,
        P_POW  = 13'h0200,
        P_LJ   = 13'h0400,
        P_EPS  = 13'h0800,
        P_SUM  = 13'h1000
    } t_pstate;

    t_pstate            r_state;
    logic [5:0]         r_cnt;
    logic [1:0]         r_pstep;
    logic               r_done;

    t_ref_entry         r_ref;
    logic signed [15:0] r_pq;
    logic [15:0]        r_prad;
    logic [6:0]         r_pel;
    logic [24:0]        r_dx, r_dy, r_dz;
    logic [49:0]        r_prod;
    logic [49:0]        r_r2;
    logic [30:0]        r_qmag;
    logic               r_qneg;
    logic [15:0]        r_sigma;
    logic               r_hb;
    logic [35:0]        r_sval;
    logic [19:0]        r_srem;
    logic [17:0]        r_root;
    logic [47:0]        r_t, r_t6, r_t12;
    logic [55:0]        r_kprod;
    logic [42:0]        r_coul;
    logic [95:0]        r_ma;
    logic [47:0]        r_mb;
    logic [95:0]        r_macc;
    logic signed [48:0] r_d;
    logic signed [65:0] r_ljp;
    logic               r_sat;
    logic signed [PE_W-1:0] r_energy;

    logic [24:0]        w_dsel;
    logic [49:0]        w_sq;
    logic [49:0]        w_cut;
    logic               w_skip;
    logic               w_hb_el;
    logic signed [31:0] w_qq;
    logic [16:0]        w_rsum;
    logic [21:0]        w_srsh;
    logic [21:0]        w_trial;
    logic               w_sge;
    logic               w_div_start;
    logic [DIV_NW-1:0]  w_div_num;
    logic               w_div_done;
    logic [DIV_NW-1:0]  w_quot;
    logic [55:0]        w_kprod;
    logic [79:0]        w_pp;
    logic               w_pclip;
    logic [47:0]        w_pval;
    logic signed [49:0] w_d;
    logic               w_dclip;
    logic signed [48:0] w_dcl;
    logic signed [65:0] w_ljp;
    logic signed [48:0] w_lj;
    logic signed [49:0] w_coul;
    logic signed [49:0] w_hbv;
    logic signed [49:0] w_energy;

    function automatic logic [24:0] f_absdiff(logic [23:0] a, logic [23:0] b);
        logic signed [24:0] d;
        d = $signed({a[23], a}) - $signed({b[23], b});
        return d[24] ? 25'(-d) : 25'(d);
    endfunction

    // squared distance, one axis per cycle
    always_comb begin
        unique case (r_cnt[1:0])
            2'd0:    w_dsel = r_dx;
            2'd1:    w_dsel = r_dy;
            default: w_dsel = r_dz;
        endcase
    end
    assign w_sq = w_dsel * w_dsel;

    assign w_cut  = {14'd0, i_cfg.cutoff, 12'd0};
    assign w_skip = (r_r2 == '0) || (r_r2 > w_cut);
    assign w_hb_el = ((r_ref.element == EL_H) && ((r_pel == EL_N) || (r_pel == EL_O))) ||
                     ((r_pel == EL_H) && ((r_ref.element == EL_N) || (r_ref.element == EL_O)));
    assign w_qq   = $signed(r_ref.charge) * $signed(r_pq);
    assign w_rsum = 17'(r_ref.radius) + 17'(r_prad);

    // digit-by-digit integer square root
    assign w_srsh  = {r_srem, r_sval[35:34]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_sge   = (w_srsh >= w_trial);

    assign w_div_start = (r_state == P_TGO) || (r_state == P_CGO);
    assign w_div_num   = (r_state == P_TGO) ? DIV_NW'({r_sigma, 16'd0}) : r_kprod[54:12];

    pbe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_root),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_kprod = COULOMB_K * r_qmag;

    // Q16 product with clip at 2^47
    assign w_pp    = r_macc[95:16];
    assign w_pclip = (w_pp > 80'(POW_CAP));
    assign w_pval  = w_pclip ? POW_CAP : w_pp[47:0];

    assign w_d     = $signed({2'b00, r_t12}) - $signed({1'b0, r_t6, 1'b0});
    assign w_dclip = (w_d > D_CAP) || (w_d < D_NCAP);
    always_comb begin
        if (w_d > D_CAP) begin
            w_dcl = D_CAP[48:0];
        end else if (w_d < D_NCAP) begin
            w_dcl = D_NCAP[48:0];
        end else begin
            w_dcl = w_d[48:0];
        end
    end

    assign w_ljp    = $signed({1'b0, i_cfg.eps}) * r_d;
    assign w_lj     = r_ljp[64:16];
    assign w_coul   = r_qneg ? -$signed({7'd0, r_coul}) : $signed({7'd0, r_coul});
    assign w_hbv    = r_hb ? 50'(i_cfg.hbond) : '0;
    assign w_energy = $signed({w_lj[48], w_lj}) + w_coul + w_hbv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
            r_cnt   <= '0;
            r_pstep <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                P_IDLE: begin
                    if (i_start) begin
                        r_state <= P_SQ;
                        r_cnt   <= '0;
                    end
                end
                P_SQ: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'd3) begin
                        r_state <= P_CHK;
                    end
                end
                P_CHK: begin
                    r_cnt <= '0;
                    if (w_skip) begin
                        r_done  <= 1'b1;
                        r_state <= P_IDLE;
                    end else begin
                        r_state <= P_SQRT;
                    end
                end
                P_SQRT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'(SQRT_STEPS - 1)) begin
                        r_state <= P_TGO;
                    end
                end
                P_TGO:  r_state <= P_DIVT;
                P_DIVT: begin
                    if (w_div_done) begin
                        r_state <= P_KMUL;
                    end
                end
                P_KMUL: r_state <= P_CGO;
                P_CGO:  r_state <= P_DIVC;
                P_DIVC: begin
                    if (w_div_done) begin
                        r_state <= P_POW;
                        r_pstep <= '0;
                    end
                end
                P_POW: begin
                    if (r_mb == '0) begin
                        r_pstep <= r_pstep + 1'b1;
                        if (r_pstep == 2'd3) begin
                            r_state <= P_LJ;
                        end
                    end
                end
                P_LJ:  r_state <= P_EPS;
                P_EPS: r_state <= P_SUM;
                P_SUM: begin
                    r_done  <= 1'b1;
                    r_state <= P_IDLE;
                end
                default: r_state <= P_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            P_IDLE: begin
                if (i_start) begin
                    r_ref    <= i_ref;
                    r_pq     <= i_probe.partial_charge;
                    r_prad   <= i_probe.vdw_radius;
                    r_pel    <= i_probe.element;
                    r_dx     <= f_absdiff(i_ref.pos_x, i_probe.pos_x);
                    r_dy     <= f_absdiff(i_ref.pos_y, i_probe.pos_y);
                    r_dz     <= f_absdiff(i_ref.pos_z, i_probe.pos_z);
                    r_r2     <= '0;
                    r_sat    <= 1'b0;
                    r_energy <= '0;
                end
            end
            P_SQ: begin
                if (r_cnt != 6'd3) begin
                    r_prod <= w_sq;
                end
                if (r_cnt != 6'd0) begin
                    r_r2 <= r_r2 + r_prod;
                end
            end
            P_CHK: begin
                r_qneg  <= w_qq[31];
                r_qmag  <= w_qq[31] ? 31'(-w_qq) : w_qq[30:0];
                r_sigma <= w_rsum[16:1];
                r_hb    <= w_hb_el && (r_r2 >= HB_LO_R2) && (r_r2 <= HB_HI_R2);
                r_sval  <= r_r2[35:0];
                r_srem  <= '0;
                r_root  <= '0;
            end
            P_SQRT: begin
                r_sval <= {r_sval[33:0], 2'b00};
                if (w_sge) begin
                    r_srem <= 20'(w_srsh - w_trial);
                    r_root <= {r_root[16:0], 1'b1};
                end else begin
                    r_srem <= w_srsh[19:0];
                    r_root <= {r_root[16:0], 1'b0};
                end
            end
            P_DIVT: begin
                if (w_div_done) begin
                    r_t <= 48'(w_quot);
                end
            end
            P_KMUL: r_kprod <= w_kprod;
            P_DIVC: begin
                if (w_div_done) begin
                    r_coul <= w_quot;
                    r_ma   <= 96'(r_t);
                    r_mb   <= r_t;
                    r_macc <= '0;
                end
            end
            P_POW: begin
                if (r_mb != '0) begin
                    if (r_mb[0]) begin
                        r_macc <= r_macc + r_ma;
                    end
                    r_ma <= {r_ma[94:0], 1'b0};
                    r_mb <= {1'b0, r_mb[47:1]};
                end else begin
                    // t2 = t*t, t3 = t2*t, t6 = t3*t3, t12 = t6*t6
                    if (w_pclip) begin
                        r_sat <= 1'b1;
                    end
                    r_macc <= '0;
                    r_ma   <= 96'(w_pval);
                    unique case (r_pstep)
                        2'd0:    r_mb <= r_t;
                        2'd1:    r_mb <= w_pval;
                        2'd2: begin
                            r_t6 <= w_pval;
                            r_mb <= w_pval;
                        end
                        default: begin
                            r_t12 <= w_pval;
                            r_mb  <= '0;
                        end
                    endcase
                end
            end
            P_LJ: begin
                r_d <= w_dcl;
                if (w_dclip) begin
                    r_sat <= 1'b1;
                end
            end
            P_EPS: r_ljp <= w_ljp;
            P_SUM: r_energy <= w_energy;
            default: ;
        endcase
    end

    assign o_res = '{done: r_done, sat: r_sat, energy: r_energy};

endmodule

[src/pairwise_binding_energy.sv]
// Top level of the pairwise binding energy block: reference store, probe walk,
// accumulator, output register. Depends on pbe_pkg, pbe_ram and pbe_pair.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (t_out_item)
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  A probe walks every stored atom in turn: a store fetch, then the pair
//  sequencer. A pair outside the cutoff or coincident ends at the cutoff
//  check; any other runs the 18-step square root, two 43-step divides and
//  four bit-serial power products. Reset is synchronous, active low; the
//  store itself needs no clearing pass. The output register lets the next
//  item in while a result waits; a last probe holds in its final state only
//  until that register is free.
module pairwise_binding_energy import pbe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    typedef enum logic [4:0] {
        T_IDLE = 5'b00001,
        T_RD   = 5'b00010,
        T_GO   = 5'b00100,
        T_PAIR = 5'b01000,
        T_FIN  = 5'b10000
    } t_state;

    t_state             r_state;
    logic [REF_CW-1:0]  r_count;
    logic [REF_CW-1:0]  r_k;
    logic               r_pending;
    logic signed [47:0] r_acc;
    logic               r_sat;
    t_in_item           r_probe;
    logic               r_out_valid;
    t_out_item          r_out;
    t_cfg               r_cfg;

    logic               w_in_xfer;
    logic               w_load;
    logic               w_probe;
    logic [REF_CW-1:0]  w_wr_idx;
    logic               w_room;
    logic [REF_CW-1:0]  w_k_nx;
    t_ref_entry         w_wr_entry;
    logic [REF_W-1:0]   w_rdata;
    t_pair_res          w_pres;
    logic signed [50:0] w_sum;
    logic               w_clip;
    logic signed [47:0] n_acc;
    logic               w_fin_go;

    // take register writes only while no probe walk is running
    assign o_in_ready  = (r_state == T_IDLE);
    assign o_cfg_ready = (r_state == T_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_load      = w_in_xfer && !i_in_data.kind;
    assign w_probe     = w_in_xfer && i_in_data.kind;

    // first load of a new set writes from entry zero; drop loads once full
    assign w_wr_idx = r_pending ? '0 : r_count;
    assign w_room   = (w_wr_idx < REF_CW'(REF_ATOMS));
    assign w_k_nx   = r_k + 1'b1;

    assign w_wr_entry = '{element: i_in_data.element,
                          pos_x:   i_in_data.pos_x,
                          pos_y:   i_in_data.pos_y,
                          pos_z:   i_in_data.pos_z,
                          charge:  i_in_data.partial_charge,
                          radius:  i_in_data.vdw_radius};

    pbe_ram #(
        .WIDTH (REF_W),
        .DEPTH (REF_ATOMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_load && w_room),
        .i_waddr (w_wr_idx[REF_AW-1:0]),
        .i_wdata (w_wr_entry),
        .i_re    (r_state == T_RD),
        .i_raddr (r_k[REF_AW-1:0]),
        .o_rdata (w_rdata)
    );

    pbe_pair u_pair (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == T_GO),
        .i_probe (r_probe),
        .i_ref   (t_ref_entry'(w_rdata)),
        .i_cfg   (r_cfg),
        .o_res   (w_pres)
    );

    // saturating accumulate of one pair term
    assign w_sum  = $signed({{3{r_acc[47]}}, r_acc}) + $signed({w_pres.energy[PE_W-1], w_pres.energy});
    assign w_clip = (w_sum > ACC_MAX) || (w_sum < ACC_MIN);
    always_comb begin
        if (w_sum > ACC_MAX) begin
            n_acc = ACC_MAX[47:0];
        end else if (w_sum < ACC_MIN) begin
            n_acc = ACC_MIN[47:0];
        end else begin
            n_acc = w_sum[47:0];
        end
    end

    assign w_fin_go = (r_state == T_FIN) && r_probe.last && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_count     <= '0;
            r_k         <= '0;
            r_pending   <= 1'b1;
            r_acc       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg       <= '{eps: EPS_RESET, cutoff: CUTOFF_RESET, hbond: HBOND_RESET};
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_EPS:    r_cfg.eps    <= i_cfg_data[15:0];
                    CFG_CUTOFF: r_cfg.cutoff <= i_cfg_data;
                    CFG_HBOND:  r_cfg.hbond  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                T_IDLE: begin
                    if (w_load) begin
                        r_pending <= 1'b0;
                        if (w_room) begin
                            r_count <= w_wr_idx + 1'b1;
                        end
                    end
                    if (w_probe) begin
                        r_k     <= '0;
                        r_state <= (r_count == '0) ? T_FIN : T_RD;
                    end
                end
                T_RD: r_state <= T_GO;
                T_GO: r_state <= T_PAIR;
                T_PAIR: begin
                    if (w_pres.done) begin
                        r_acc   <= n_acc;
                        r_sat   <= r_sat | w_pres.sat | w_clip;
                        r_k     <= w_k_nx;
                        r_state <= (w_k_nx < r_count) ? T_RD : T_FIN;
                    end
                end
                T_FIN: begin
                    // a last probe emits and clears; the next load opens a new set
                    if (!r_probe.last) begin
                        r_state <= T_IDLE;
                    end else if (w_fin_go) begin
                        r_acc     <= '0;
                        r_sat     <= 1'b0;
                        r_pending <= 1'b1;
                        r_state   <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_probe) begin
            r_probe <= i_in_data;
        end
        if (w_fin_go) begin
            r_out <= '{total_energy: r_acc, saturated: r_sat};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= REF_CW'(REF_ATOMS))
        else $error("reference count beyond store size");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_RD) |-> (r_k < r_count))
        else $error("store fetch past last loaded atom");

    a_done_in_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pres.done |-> (r_state == T_PAIR))
        else $error("pair result outside the walk");

    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin_go |=> (r_acc == '0 && !r_sat && r_pending && r_out_valid))
        else $error("accumulator not cleared after emit");
`endif

endmodule

[tb/sv/pairwise_binding_energy_tb.sv]
// Self-checking testbench for pairwise_binding_energy: directed and random reference
// sets and probes under random idling on the input and output channels. Depends on pbe_pkg and the RTL.

module pairwise_binding_energy_tb;
    import pbe_pkg::*;

    // Predicts totals from the loaded reference set and the register values,
    // and compares each emitted total with the oldest one outstanding.
    class energy_scoreboard;
        t_ref_entry         atoms[REF_ATOMS];
        int unsigned        n_atoms;
        longint             acc;
        bit                 clipped;
        bit                 fresh_set;
        logic [15:0]        eps;
        logic [23:0]        cutoff;
        logic signed [23:0] hbond;
        t_out_item          totals_q[$];
        int unsigned        errors;

        function new();
            n_atoms   = 0;
            acc       = 0;
            clipped   = 1'b0;
            fresh_set = 1'b1;
            eps       = EPS_RESET;
            cutoff    = CUTOFF_RESET;
            hbond     = HBOND_RESET;
            errors    = 0;
        endfunction

        function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
            case (idx)
                CFG_EPS:    eps    = val[15:0];
                CFG_CUTOFF: cutoff = val;
                CFG_HBOND:  hbond  = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return totals_q.size();
        endfunction

        // Floor square root, bit by bit.
        function bit [63:0] root_floor(bit [63:0] v);
            bit [63:0] res, b;
            res = 0;
            b   = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v   = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        // Q.16 product; clip at 2^47 on overflow of 64 bits or of the cap.
        function bit [63:0] pow_mul(bit [63:0] a, bit [63:0] b);
            bit [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            if (p[127:64] != 0) begin
                clipped = 1'b1;
                return 64'd1 << 47;
            end
            p = p >> 16;
            if (p > (128'd1 << 47)) begin
                clipped = 1'b1;
                return 64'd1 << 47;
            end
            return p[63:0];
        endfunction

        function longint pair_term(t_ref_entry a, t_in_item p);
            longint    dx, dy, dz, d, lj, coul, hb, qq;
            bit [63:0] r2, r, sig, t, t2, t3, t6, t12, mag, cmag;
            bit        hb_pair;
            dx = longint'(a.pos_x) - longint'(p.pos_x);
            dy = longint'(a.pos_y) - longint'(p.pos_y);
            dz = longint'(a.pos_z) - longint'(p.pos_z);
            r2 = dx * dx + dy * dy + dz * dz;
            if (r2 > ({40'd0, cutoff} << 12) || r2 == 0) return 0;
            r   = root_floor(r2);
            sig = ({48'd0, a.radius} + {48'd0, p.vdw_radius}) >> 1;
            t   = (sig << 16) / r;
            t2  = pow_mul(t, t);
            t3  = pow_mul(t2, t);
            t6  = pow_mul(t3, t3);
            t12 = pow_mul(t6, t6);
            d = longint'(t12) - 2 * longint'(t6);
            if (d > (64'sd1 <<< 47)) begin
                d = 64'sd1 <<< 47;
                clipped = 1'b1;
            end
            if (d < -(64'sd1 <<< 47)) begin
                d = -(64'sd1 <<< 47);
                clipped = 1'b1;
            end
            lj   = (longint'(eps) * d) >>> 16;
            qq   = longint'(a.charge) * longint'(p.partial_charge);
            mag  = (qq < 0) ? -qq : qq;
            cmag = (64'(COULOMB_K) * mag) / (r << 12);
            coul = (qq < 0) ? -longint'(cmag) : longint'(cmag);
            hb_pair = (a.element == EL_H && (p.element == EL_N || p.element == EL_O)) ||
                      (p.element == EL_H && (a.element == EL_N || a.element == EL_O));
            hb = 0;
            if (hb_pair && r2 >= 64'(HB_LO_R2) && r2 <= 64'(HB_HI_R2))
                hb = longint'(hbond);
            return lj + coul + hb;
        endfunction

        function void note_input(t_in_item it);
            longint    s;
            t_out_item o;
            if (!it.kind) begin
                if (fresh_set) begin
                    n_atoms   = 0;
                    fresh_set = 1'b0;
                end
                if (n_atoms < REF_ATOMS) begin
                    atoms[n_atoms] = '{it.element, it.pos_x, it.pos_y, it.pos_z,
                                       it.partial_charge, it.vdw_radius};
                    n_atoms++;
                end
                return;
            end
            for (int k = 0; k < n_atoms; k++) begin
                s = acc + pair_term(atoms[k], it);
                if (s > longint'(ACC_MAX)) begin
                    s = ACC_MAX;
                    clipped = 1'b1;
                end
                if (s < longint'(ACC_MIN)) begin
                    s = ACC_MIN;
                    clipped = 1'b1;
                end
                acc = s;
            end
            if (!it.last) return;
            o.total_energy = acc[47:0];
            o.saturated    = clipped;
            totals_q.push_back(o);
            acc       = 0;
            clipped   = 1'b0;
            fresh_set = 1'b1;
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (totals_q.size() == 0) begin
                $display("%0t: unexpected total %0d sat %0b", $time,
                         got.total_energy, got.saturated);
                errors++;
                return;
            end
            want = totals_q.pop_front();
            if (got.total_energy !== want.total_energy) begin
                $display("%0t: total_energy expected %0d actual %0d", $time,
                         want.total_energy, got.total_energy);
                errors++;
            end
            if (got.saturated !== want.saturated) begin
                $display("%0t: saturated expected %0b actual %0b", $time,
                         want.saturated, got.saturated);
                errors++;
            end
        endfunction
    endclass

    localparam int     ANG        = 4096;     // 1 angstrom in Q.12
    localparam int     RAND_ITEMS = 1080;
    localparam longint MAX_CYCLES = 6_000_000;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              in_valid    = 1'b0;
    t_in_item          in_data     = '0;
    logic              out_ready   = 1'b0;
    logic              cfg_valid   = 1'b0;
    logic [CFG_IW-1:0] cfg_index   = CFG_EPS;
    logic [CFG_DW-1:0] cfg_data    = '0;
    logic              o_in_ready;
    logic              o_out_valid;
    t_out_item         o_out_data;
    logic              o_cfg_ready;

    energy_scoreboard model = new();
    longint           cycles = 0;
    int               sent = 0;
    bit               no_gaps = 1'b0;
    int               stall_left = 0;

    pairwise_binding_energy i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one; none while in burst mode.
    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver side: random stalls, counted at each edge.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
        end
        if (i_rst_n && o_out_valid && out_ready) model.check_result(o_out_data);
    end

    always @(posedge i_clk) begin
        if (cycles >= MAX_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Hold valid and payload until the transfer; lower valid only to open a gap.
    task automatic push_item(t_in_item it);
        int g;
        g = pick_gap();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        model.note_input(it);
        sent++;
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        model.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop sending, wait for every outstanding total, then let a probe that
    // produces no total finish its walk before anything else changes.
    task automatic drain();
        in_valid <= 1'b0;
        while (model.pending() > 0) @(posedge i_clk);
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    function automatic t_in_item make_atom(bit kind, logic [6:0] el, int x, int y, int z,
                                           int q, int rad, bit last);
        t_in_item it;
        it.kind           = kind;
        it.element        = el;
        it.pos_x          = 24'(x);
        it.pos_y          = 24'(y);
        it.pos_z          = 24'(z);
        it.partial_charge = 16'(q);
        it.vdw_radius     = 16'(rad);
        it.last           = last;
        return it;
    endfunction

    function automatic t_in_item noise_item();
        t_in_item     it;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        it  = raw[$bits(t_in_item)-1:0];
        return it;
    endfunction

    function automatic logic [6:0] pick_element();
        case ($urandom_range(0, 4))
            0: return EL_H;
            1: return EL_N;
            2: return EL_O;
            3: return 7'd6;
            default: return 7'($urandom_range(0, 127));
        endcase
    endfunction

    // Atom scattered around a center; mostly typical radii, some full range.
    function automatic t_in_item near_atom(bit kind, int cx, int cy, int cz, bit last);
        int spread, rad;
        spread = ($urandom_range(0, 3) == 0) ? 16 * ANG : 4 * ANG;
        rad = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
                                          : $urandom_range(4096, 12288);
        return make_atom(kind, pick_element(),
                         cx + $urandom_range(0, 2 * spread) - spread,
                         cy + $urandom_range(0, 2 * spread) - spread,
                         cz + $urandom_range(0, 2 * spread) - spread,
                         $urandom_range(0, 65535) - 32768, rad,
                         ($urandom_range(0, 1) == 1) && (kind == 1'b0 || last));
    endfunction

    // One well-formed set: loads, then probes ending in the last one, with an
    // occasional load slipped in among the probes and now and then a noise item after.
    task automatic random_set();
        int cx, cy, cz, nl, np;
        cx = $urandom_range(0, 16_000_000) - 8_000_000;
        cy = $urandom_range(0, 16_000_000) - 8_000_000;
        cz = $urandom_range(0, 16_000_000) - 8_000_000;
        nl = $urandom_range(1, 6);
        np = $urandom_range(1, 4);
        no_gaps = ($urandom_range(0, 3) == 0);
        repeat (nl) push_item(near_atom(1'b0, cx, cy, cz, 1'b0));
        for (int j = 0; j < np; j++) begin
            if ($urandom_range(0, 7) == 0) push_item(near_atom(1'b0, cx, cy, cz, 1'b0));
            push_item(near_atom(1'b1, cx, cy, cz, j == np - 1));
        end
        if ($urandom_range(0, 7) == 0) push_item(noise_item());
    endtask

    // Fill the store past capacity: stored atoms sit far from the probe,
    // the dropped ones right next to it, so a stored overflow shows up.
    task automatic fill_store();
        for (int k = 0; k < REF_ATOMS; k++)
            push_item(make_atom(1'b0, pick_element(), -8_000_000 + $urandom_range(0, 65535),
                                $urandom_range(0, 65535), 0, $urandom_range(0, 65535),
                                $urandom_range(0, 65535), 1'b0));
        repeat (3) push_item(make_atom(1'b0, EL_O, 8_000_000 + 2 * ANG, 0, 0, 32767,
                                       8192, 1'b0));
        push_item(make_atom(1'b1, EL_H, 8_000_000, 0, 0, 32767, 8192, 1'b1));
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty store, hydrogen-bond window edges, coincident atoms,
        // the cutoff boundary, a load among probes, power clipping, corners.
        push_item(make_atom(1'b1, EL_H, 0, 0, 0, 0, 0, 1'b1));
        push_item(make_atom(1'b0, EL_H, 0, 0, 0, 32767, 65535, 1'b1));
        push_item(make_atom(1'b0, EL_O, 6144, 0, 0, -32768, 0, 1'b0));
        push_item(make_atom(1'b0, EL_N, 0, 10240, 0, 1000, 6144, 1'b0));
        push_item(make_atom(1'b0, 7'd127, 0, 0, -12 * ANG, 0, 12288, 1'b0));
        push_item(make_atom(1'b0, 7'd0, -8388608, 8388607, -8388608, 4096, 4096, 1'b0));
        push_item(make_atom(1'b1, EL_H, 0, 0, 0, 4096, 6144, 1'b0));
        push_item(make_atom(1'b0, EL_O, ANG, ANG, 0, -4096, 8192, 1'b0));
        push_item(make_atom(1'b1, EL_O, 1, 0, 0, 32767, 65535, 1'b1));
        push_item(make_atom(1'b0, EL_H, 8388607, 8388607, 8388607, -32768, 65535, 1'b0));
        push_item(make_atom(1'b1, EL_N, 8388607, 8388607, 8388607 - 2 * ANG, -32768, 0,
                            1'b0));
        push_item(make_atom(1'b1, EL_O, 8388607, 8388607 - ANG, 8388607, 32767, 40000,
                            1'b1));
        drain();

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: ;
                1: begin
                    write_reg(CFG_EPS, 24'd65535);
                    write_reg(CFG_CUTOFF, 24'hFFFFFF);
                    write_reg(CFG_HBOND, 24'h7FFFFF);
                end
                2: begin
                    write_reg(CFG_EPS, 24'd0);
                    write_reg(CFG_CUTOFF, 24'd0);
                    write_reg(CFG_HBOND, 24'h800000);
                end
                3: begin
                    write_reg(CFG_EPS, 24'($urandom_range(0, 65535)));
                    write_reg(CFG_CUTOFF, 24'($urandom_range(0, 1_200_000)));
                    write_reg(CFG_HBOND, 24'($urandom));
                end
                default: begin
                    write_reg(CFG_EPS, 24'(EPS_RESET));
                    write_reg(CFG_CUTOFF, CUTOFF_RESET);
                    write_reg(CFG_HBOND, HBOND_RESET);
                end
            endcase
            if (ph == 2) begin
                fill_store();
                drain();
            end
            while (sent < 12 + (ph + 1) * (RAND_ITEMS / 5)) begin
                random_set();
                // past mid-phase, hold off after each set until all totals are back
                if (ph == 1 && sent > 12 + RAND_ITEMS / 5 + 100 && model.pending() > 0)
                    drain();
            end
            drain();
        end

        in_valid <= 1'b0;
        while (model.pending() > 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (model.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
src/pbe_pkg.sv
src/pbe_ram.sv
src/pbe_div.sv
src/pbe_pair.sv
src/pairwise_binding_energy.sv
tb/sv/pairwise_binding_energy_tb.sv
